// ===== rtl/cltc_pkg.sv =====
// cltc_pkg: shared types and codes of the complete-linkage threshold clusterer
// no dependencies; used by the controller, datapath, top level and checker

package cltc_pkg;

    // input action codes
    localparam logic [1:0] ACT_LABEL = 2'd0;
    localparam logic [1:0] ACT_DIST  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    // configuration register indexes
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_COUNT     = 1'b1;

    // reset values of the configuration registers
    localparam logic [15:0] THRESHOLD_RESET = 16'd0;
    localparam logic [6:0]  COUNT_RESET     = 7'd64;

    // controller states, also the phase that the datapath executes
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_CLEAR,
        ST_ACCUM,
        ST_SCAN,
        ST_MERGE,
        ST_RELABEL,
        ST_EMIT
    } cltc_state_t;

    typedef struct packed {
        cltc_state_t phase;
    } cltc_cmd_t;

    typedef struct packed {
        logic done;
        logic multi_live;
        logic merge_ok;
    } cltc_status_t;

endpackage

// ===== rtl/cltc_ram.sv =====
// cltc_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module cltc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cltc_ctrl.sv =====
// cltc_ctrl: run sequencer of the clusterer
// depends on cltc_pkg

module cltc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            action,
    input  cltc_pkg::cltc_status_t sts,
    output cltc_pkg::cltc_cmd_t   cmd,
    output logic                  in_stall
);

    cltc_pkg::cltc_state_t state_reg;
    cltc_pkg::cltc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cltc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cltc_pkg::ST_IDLE:
            begin
                if (in_valid && action == cltc_pkg::ACT_RUN)
                begin
                    state_next = cltc_pkg::ST_INIT;
                end
            end
            cltc_pkg::ST_INIT:
            begin
                if (sts.done)
                begin
                    state_next = cltc_pkg::ST_CLEAR;
                end
            end
            cltc_pkg::ST_CLEAR:
            begin
                if (sts.done)
                begin
                    state_next = cltc_pkg::ST_ACCUM;
                end
            end
            cltc_pkg::ST_ACCUM:
            begin
                if (sts.done)
                begin
                    state_next = sts.multi_live ? cltc_pkg::ST_SCAN : cltc_pkg::ST_EMIT;
                end
            end
            cltc_pkg::ST_SCAN:
            begin
                if (sts.done)
                begin
                    state_next = sts.merge_ok ? cltc_pkg::ST_MERGE : cltc_pkg::ST_EMIT;
                end
            end
            cltc_pkg::ST_MERGE:
            begin
                if (sts.done)
                begin
                    state_next = cltc_pkg::ST_RELABEL;
                end
            end
            cltc_pkg::ST_RELABEL:
            begin
                if (sts.done)
                begin
                    state_next = sts.multi_live ? cltc_pkg::ST_SCAN : cltc_pkg::ST_EMIT;
                end
            end
            cltc_pkg::ST_EMIT:
            begin
                if (sts.done)
                begin
                    state_next = cltc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cltc_pkg::ST_IDLE;
            end
        endcase
        cmd.phase = state_reg;
        in_stall  = (state_reg != cltc_pkg::ST_IDLE);
    end

endmodule

// ===== rtl/cltc_datapath.sv =====
// cltc_datapath: stores, counters, linkage matrix and output register of the clusterer
// depends on cltc_pkg and cltc_ram

module cltc_datapath #(
    parameter int MAX_INDIVIDUALS = 64,
    parameter int DIST_WIDTH      = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cltc_pkg::cltc_cmd_t    cmd,
    output cltc_pkg::cltc_status_t sts,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   in_accept,
    input  logic [1:0]             action,
    input  logic [5:0]             row_index,
    input  logic [5:0]             col_index,
    input  logic [6:0]             start_label,
    input  logic [15:0]            distance_value,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [5:0]             individual,
    output logic [6:0]             cluster_label,
    output logic                   last
);

    localparam int IW = $clog2(MAX_INDIVIDUALS);
    localparam int NW = $clog2(MAX_INDIVIDUALS + 1);
    localparam int DEPTH2 = MAX_INDIVIDUALS * MAX_INDIVIDUALS;
    localparam int AW = $clog2(DEPTH2);
    localparam int DW = DIST_WIDTH;
    localparam int TW = (DW > 16) ? DW : 16;
    localparam int LW = ((IW > 7) ? IW : 7) + 1;

    // slot pair (a, b) to linkage matrix address
    function automatic logic [AW-1:0] pair_addr(input logic [IW-1:0] a,
                                                input logic [IW-1:0] b);
        logic [AW:0] full;
        full = (AW+1)'(a) * (AW+1)'(MAX_INDIVIDUALS) + (AW+1)'(b);
        return full[AW-1:0];
    endfunction

    // configuration registers
    logic [15:0] thr_reg;
    logic [6:0]  cnt_reg;

    // sequencing counters
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [2:0]    sub_reg, sub_next;
    logic [AW-1:0] daddr_reg, daddr_next;

    // cluster bookkeeping
    logic [MAX_INDIVIDUALS-1:0] live_reg, live_next;
    logic [NW-1:0]              lcnt_reg, lcnt_next;
    logic                       found_reg, found_next;
    logic [DW-1:0]              best_reg, best_next;
    logic [IW-1:0]              lo_reg, lo_next;
    logic [IW-1:0]              hi_reg, hi_next;
    logic [IW-1:0]              a_reg, a_next;
    logic [DW-1:0]              t_reg, t_next;

    // scan pipeline stage
    logic          pv_reg, pv_next;
    logic [IW-1:0] pa_reg, pa_next;
    logic [IW-1:0] pb_reg, pb_next;

    // output register
    logic          ov_reg, ov_next;
    logic [5:0]    oind_reg, oind_next;
    logic [6:0]    olab_reg, olab_next;
    logic          olast_reg, olast_next;

    // memory ports
    logic          lab_we;
    logic [IW-1:0] lab_waddr, lab_wdata, lab_raddr, lab_rdata;
    logic          dist_we;
    logic [AW-1:0] dist_waddr, dist_raddr;
    logic [DW-1:0] dist_wdata, dist_rdata;
    logic          pm_we;
    logic [AW-1:0] pm_waddr, pm_raddr;
    logic [DW-1:0] pm_wdata, pm_rdata;

    // working values
    logic [NW-1:0] n_eff;
    logic [IW-1:0] nm1;
    logic          i_last, j_last, done;
    logic [IW-1:0] slot_clamped;
    logic [6:0]    lab_dec;
    logic [AW:0]   load_addr;
    logic          out_load;

    cltc_ram #(.WIDTH(IW), .DEPTH(MAX_INDIVIDUALS)) u_lab_ram (
        .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
        .raddr(lab_raddr), .rdata(lab_rdata)
    );

    cltc_ram #(.WIDTH(DW), .DEPTH(DEPTH2)) u_dist_ram (
        .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
        .raddr(dist_raddr), .rdata(dist_rdata)
    );

    cltc_ram #(.WIDTH(DW), .DEPTH(DEPTH2)) u_pm_ram (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata)
    );

    // effective individual count, clamped to 1..MAX_INDIVIDUALS
    always_comb
    begin
        if (cnt_reg == 7'd0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(cnt_reg) > MAX_INDIVIDUALS)
        begin
            n_eff = NW'(MAX_INDIVIDUALS);
        end
        else
        begin
            n_eff = NW'(cnt_reg);
        end
    end

    assign nm1    = IW'(n_eff - NW'(1));
    assign i_last = (i_reg == nm1);
    assign j_last = (j_reg == nm1);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= cltc_pkg::THRESHOLD_RESET;
            cnt_reg <= cltc_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cltc_pkg::CFG_THRESHOLD)
            begin
                thr_reg <= cfg_data;
            end
            else
            begin
                cnt_reg <= cfg_data[6:0];
            end
        end
    end

    // load decode: label to slot, distance address
    always_comb
    begin
        lab_dec = (start_label == 7'd0) ? 7'd0 : start_label - 7'd1;
        if (int'(lab_dec) > MAX_INDIVIDUALS - 1)
        begin
            slot_clamped = IW'(MAX_INDIVIDUALS - 1);
        end
        else
        begin
            slot_clamped = IW'(lab_dec);
        end
        load_addr = (AW+1)'(row_index) * (AW+1)'(n_eff) + (AW+1)'(col_index);
    end

    // phase datapath
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        sub_next   = sub_reg;
        daddr_next = daddr_reg;
        live_next  = live_reg;
        lcnt_next  = lcnt_reg;
        found_next = found_reg;
        best_next  = best_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        t_next     = t_reg;
        pv_next    = 1'b0;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        oind_next  = oind_reg;
        olab_next  = olab_reg;
        olast_next = olast_reg;
        out_load   = 1'b0;
        done       = 1'b0;

        lab_we     = 1'b0;
        lab_waddr  = i_reg;
        lab_wdata  = lab_rdata;
        lab_raddr  = i_reg;
        dist_we    = 1'b0;
        dist_waddr = load_addr[AW-1:0];
        dist_wdata = DW'(distance_value);
        dist_raddr = daddr_reg;
        pm_we      = 1'b0;
        pm_waddr   = pair_addr(i_reg, j_reg);
        pm_wdata   = '0;
        pm_raddr   = pair_addr(i_reg, j_reg);

        // scan compare stage, strict less keeps the first pair on ties
        if (pv_reg && pa_reg < pb_reg && live_reg[pa_reg] && live_reg[pb_reg]
            && (!found_reg || pm_rdata < best_reg))
        begin
            found_next = 1'b1;
            best_next  = pm_rdata;
            lo_next    = pa_reg;
            hi_next    = pb_reg;
        end

        case (cmd.phase)
            cltc_pkg::ST_IDLE:
            begin
                // loads, and live set cleared when a run is taken
                if (in_accept && action == cltc_pkg::ACT_LABEL)
                begin
                    lab_we    = (int'(row_index) < MAX_INDIVIDUALS);
                    lab_waddr = IW'(row_index);
                    lab_wdata = slot_clamped;
                end
                if (in_accept && action == cltc_pkg::ACT_DIST)
                begin
                    dist_we = ({2'b00, row_index} < (NW+8)'(n_eff))
                              && ({2'b00, col_index} < (NW+8)'(n_eff));
                end
                if (in_accept && action == cltc_pkg::ACT_RUN)
                begin
                    live_next = '0;
                    lcnt_next = '0;
                end
            end
            cltc_pkg::ST_INIT:
            begin
                // clamp slots to n-1 and build the live set
                found_next = 1'b0;
                if (sub_reg == 3'd0)
                begin
                    sub_next = 3'd1;
                end
                else
                begin
                    lab_we    = 1'b1;
                    lab_wdata = (lab_rdata > nm1) ? nm1 : lab_rdata;
                    if (!live_reg[lab_wdata])
                    begin
                        lcnt_next = lcnt_reg + NW'(1);
                    end
                    live_next[lab_wdata] = 1'b1;
                    sub_next = 3'd0;
                    i_next   = i_reg + IW'(1);
                    done     = i_last;
                end
            end
            cltc_pkg::ST_CLEAR:
            begin
                // zero the linkage matrix over n by n
                pm_we = 1'b1;
                if (j_last)
                begin
                    j_next = '0;
                    i_next = i_reg + IW'(1);
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
                done = i_last && j_last;
            end
            cltc_pkg::ST_ACCUM:
            begin
                // per element: slot of row, slot of column, matrix read, max update
                lab_raddr = (sub_reg == 3'd0) ? i_reg : j_reg;
                pm_raddr  = pair_addr(a_reg, lab_rdata);
                pm_waddr  = pair_addr(a_reg, lab_rdata);
                pm_wdata  = dist_rdata;
                sub_next  = sub_reg + 3'd1;
                if (sub_reg == 3'd1)
                begin
                    a_next = lab_rdata;
                end
                if (sub_reg == 3'd3)
                begin
                    pm_we      = (a_reg != lab_rdata) && (dist_rdata > pm_rdata);
                    sub_next   = 3'd0;
                    daddr_next = daddr_reg + AW'(1);
                    if (j_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + IW'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IW'(1);
                    end
                    done = i_last && j_last;
                end
            end
            cltc_pkg::ST_SCAN:
            begin
                // stream all pairs through the compare stage
                case (sub_reg)
                    3'd0:
                    begin
                        pv_next = 1'b1;
                        pa_next = i_reg;
                        pb_next = j_reg;
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + IW'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IW'(1);
                        end
                        if (i_last && j_last)
                        begin
                            sub_next = 3'd1;
                        end
                    end
                    3'd1:
                    begin
                        sub_next = 3'd2;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
            cltc_pkg::ST_MERGE:
            begin
                // fold row and column hi into lo by maximum
                case (sub_reg)
                    3'd0:    pm_raddr = pair_addr(lo_reg, i_reg);
                    3'd1:    pm_raddr = pair_addr(hi_reg, i_reg);
                    3'd2:    pm_raddr = pair_addr(i_reg, lo_reg);
                    default: pm_raddr = pair_addr(i_reg, hi_reg);
                endcase
                sub_next = sub_reg + 3'd1;
                if (sub_reg == 3'd1 || sub_reg == 3'd3)
                begin
                    t_next = pm_rdata;
                end
                pm_wdata = (pm_rdata > t_reg) ? pm_rdata : t_reg;
                if (sub_reg == 3'd2)
                begin
                    pm_we    = 1'b1;
                    pm_waddr = pair_addr(lo_reg, i_reg);
                end
                if (sub_reg == 3'd4)
                begin
                    pm_we    = 1'b1;
                    pm_waddr = pair_addr(i_reg, lo_reg);
                    sub_next = 3'd0;
                    i_next   = i_reg + IW'(1);
                    if (i_last)
                    begin
                        done              = 1'b1;
                        live_next[hi_reg] = 1'b0;
                        lcnt_next         = lcnt_reg - NW'(1);
                    end
                end
            end
            cltc_pkg::ST_RELABEL:
            begin
                // move members of hi to lo
                found_next = 1'b0;
                if (sub_reg == 3'd0)
                begin
                    sub_next = 3'd1;
                end
                else
                begin
                    lab_we    = (lab_rdata == hi_reg);
                    lab_wdata = lo_reg;
                    sub_next  = 3'd0;
                    i_next    = i_reg + IW'(1);
                    done      = i_last;
                end
            end
            cltc_pkg::ST_EMIT:
            begin
                // one item per individual into the output register
                if (sub_reg == 3'd0)
                begin
                    sub_next = 3'd1;
                end
                else if (!ov_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    oind_next  = 6'(i_reg);
                    olab_next  = 7'(LW'(lab_rdata) + LW'(1));
                    olast_next = i_last;
                    sub_next   = 3'd0;
                    i_next     = i_reg + IW'(1);
                    done       = i_last;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        if (done)
        begin
            i_next     = '0;
            j_next     = '0;
            sub_next   = '0;
            daddr_next = '0;
        end

        if (out_load)
        begin
            ov_next = 1'b1;
        end
        else if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            j_reg     <= '0;
            sub_reg   <= '0;
            daddr_reg <= '0;
            live_reg  <= '0;
            lcnt_reg  <= '0;
            found_reg <= 1'b0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            sub_reg   <= sub_next;
            daddr_reg <= daddr_next;
            live_reg  <= live_next;
            lcnt_reg  <= lcnt_next;
            found_reg <= found_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        t_reg     <= t_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        oind_reg  <= oind_next;
        olab_reg  <= olab_next;
        olast_reg <= olast_next;
    end

    // status to the controller
    assign sts.done       = done;
    assign sts.multi_live = (lcnt_reg > NW'(1));
    assign sts.merge_ok   = found_reg && (TW'(best_reg) < TW'(thr_reg));

    assign out_valid     = ov_reg;
    assign individual    = oind_reg;
    assign cluster_label = olab_reg;
    assign last          = olast_reg;

endmodule

// ===== rtl/complete_linkage_threshold_clusterer_core.sv =====
// complete_linkage_threshold_clusterer_core: top level of the clusterer
// depends on cltc_pkg, cltc_ctrl, cltc_datapath, cltc_ram

// Label and distance load items are taken one per cycle while the block is idle.
// A run item first clamps the slots, clears the n-by-n cluster linkage matrix and
// builds it from the distance store; each merge round then scans all slot pairs,
// folds the merged slot into the kept one and relabels the individuals. The
// linkage matrix RAM has a single port pair. Results leave one per individual in
// ascending order, the final one flagged by last. Input stall stays high from the
// run item until the last result sits in the output register.

module complete_linkage_threshold_clusterer_core #(
    parameter int MAX_INDIVIDUALS = 64,
    parameter int DIST_WIDTH      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  row_index,
    input  logic [5:0]  col_index,
    input  logic [6:0]  start_label,
    input  logic [15:0] distance_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  individual,
    output logic [6:0]  cluster_label,
    output logic        last
);

    cltc_pkg::cltc_cmd_t    cmd;
    cltc_pkg::cltc_status_t sts;
    logic                   in_accept;

    assign in_accept = in_valid && !in_stall;

    cltc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    cltc_datapath #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
        .DIST_WIDTH      (DIST_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_accept      (in_accept),
        .action         (action),
        .row_index      (row_index),
        .col_index      (col_index),
        .start_label    (start_label),
        .distance_value (distance_value),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .individual     (individual),
        .cluster_label  (cluster_label),
        .last           (last)
    );

endmodule

// ===== rtl/cltc_checker.sv =====
// cltc_checker: port-level assertions for the clusterer top level
// depends on cltc_pkg; bound to complete_linkage_threshold_clusterer_core

module cltc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] action,
    input logic       out_valid,
    input logic       out_stall,
    input logic       last
);

    // a waiting item is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    // a run item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == cltc_pkg::ACT_RUN |=> in_stall)
        else $error("input taken right after a run item");

    // a final item taken while idle leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last && !in_stall |=> !out_valid)
        else $error("item after the final item of a run");

    // while idle only the final item may still wait
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid |-> last)
        else $error("idle with a non-final item pending");

endmodule

bind complete_linkage_threshold_clusterer_core cltc_checker u_cltc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last      (last)
);
